### rtl/core/hbd_pkg.sv
// Shared types, constants and arithmetic helpers of the half-band decimator.
`default_nettype none
package hbd_pkg;

    localparam int TAPS      = 27;
    localparam int MAC_STEPS = (TAPS + 1) / 4 + 1;   // folded pairs plus center tap
    localparam int STEP_W    = $clog2(MAC_STEPS);
    localparam int SAMP_W    = 16;
    localparam int PAIR_W    = SAMP_W + 1;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = 34;
    localparam int CFG_W     = 16;

    localparam logic signed [ACC_W-1:0] FILT_ROUND = 34'sd16384;
    localparam int                      FILT_SHIFT = 15;
    localparam logic signed [ACC_W-1:0] GAIN_ROUND = 34'sd128;
    localparam int                      GAIN_SHIFT = 8;
    localparam logic signed [ACC_W-1:0] SAT_MAX    = 34'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -34'sd32768;

    localparam logic [CFG_W-1:0] GAIN_RESET    = 16'd256;
    localparam logic [CFG_W-1:0] DISCARD_RESET = 16'd0;

    // Register byte addresses
    localparam logic [2:0] ADDR_MIC_GAIN      = 3'd0;
    localparam logic [2:0] ADDR_DISCARD_COUNT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_ROUND,
        ST_GAIN,
        ST_EMIT
    } hbd_state_t;

    typedef struct packed {
        logic              clear;      // restart: flush delay line, phase, load discard
        logic              discard;    // drop sample, count down
        logic              shift_in;   // push sample, toggle phase
        logic              load_work;  // fold taps into work line, clear accumulator
        logic              mac_step;   // one multiply-accumulate
        logic [STEP_W-1:0] coef_sel;
        logic              round;      // filter rounding and saturation
        logic              gain;       // gain multiply
        logic              out_load;   // round, saturate, write output register
    } hbd_cmd_t;

    typedef struct packed {
        logic discard_zero;
        logic phase;
    } hbd_status_t;

    // Folded half-band coefficients: outer pair first, center tap last
    function automatic logic signed [COEF_W-1:0] hbd_coef(input logic [STEP_W-1:0] sel);
        logic signed [COEF_W-1:0] c;
        case (sel)
            3'd0:    c = 16'sd64;
            3'd1:    c = -16'sd125;
            3'd2:    c = 16'sd322;
            3'd3:    c = -16'sd719;
            3'd4:    c = 16'sd1461;
            3'd5:    c = -16'sd3063;
            3'd6:    c = 16'sd10252;
            default: c = 16'sd16384;
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMP_W-1:0] hbd_sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SAMP_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 16'sh7fff;
        end else if (v < SAT_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[SAMP_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hbd_ctrl.sv
// Controller state machine of the half-band decimator.
`default_nettype none
module hbd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_restart,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire hbd_pkg::hbd_status_t status,
    output hbd_pkg::hbd_cmd_t        cmd
);

    hbd_pkg::hbd_state_t             state_reg, state_next;
    logic [hbd_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            accept;
    logic                            out_free;

    assign accept   = in_valid && (state_reg == hbd_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbd_pkg::ST_IDLE:
            begin
                if (accept && !in_restart && status.discard_zero && status.phase) begin
                    state_next = hbd_pkg::ST_LOAD;
                end
            end
            hbd_pkg::ST_LOAD:  state_next = hbd_pkg::ST_MAC;
            hbd_pkg::ST_MAC:
            begin
                if (step_reg == hbd_pkg::STEP_W'(hbd_pkg::MAC_STEPS - 1)) begin
                    state_next = hbd_pkg::ST_ROUND;
                end
            end
            hbd_pkg::ST_ROUND: state_next = hbd_pkg::ST_GAIN;
            hbd_pkg::ST_GAIN:  state_next = hbd_pkg::ST_EMIT;
            hbd_pkg::ST_EMIT:
            begin
                if (out_free) begin
                    state_next = hbd_pkg::ST_IDLE;
                end
            end
            default: state_next = hbd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.coef_sel   = step_reg;
        step_next      = step_reg;
        in_ready       = 1'b0;
        case (state_reg)
            hbd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept) begin
                    if (in_restart) begin
                        cmd.clear = 1'b1;
                    end else if (!status.discard_zero) begin
                        cmd.discard = 1'b1;
                    end else begin
                        cmd.shift_in = 1'b1;
                    end
                end
            end
            hbd_pkg::ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                step_next     = '0;
            end
            hbd_pkg::ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                step_next    = step_reg + 1'b1;
            end
            hbd_pkg::ST_ROUND: cmd.round = 1'b1;
            hbd_pkg::ST_GAIN:  cmd.gain  = 1'b1;
            hbd_pkg::ST_EMIT:  cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= hbd_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### rtl/core/hbd_datapath.sv
// Datapath of the half-band decimator: delay line, folded MAC, rounding and gain.
`default_nettype none
module hbd_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hbd_pkg::hbd_cmd_t                   cmd,
    input  wire logic signed [hbd_pkg::SAMP_W-1:0]   sample_in,
    input  wire logic [hbd_pkg::CFG_W-1:0]           mic_gain,
    input  wire logic [hbd_pkg::CFG_W-1:0]           discard_count,
    output hbd_pkg::hbd_status_t                     status,
    output logic signed [hbd_pkg::SAMP_W-1:0]       sample_out
);

    localparam int TAPS = hbd_pkg::TAPS;
    localparam int NW   = hbd_pkg::MAC_STEPS;

    logic signed [hbd_pkg::SAMP_W-1:0] dly_reg [TAPS];
    logic                              phase_reg;
    logic [hbd_pkg::CFG_W-1:0]         discard_reg;
    logic signed [hbd_pkg::PAIR_W-1:0] work_reg [NW];
    logic signed [hbd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [hbd_pkg::SAMP_W-1:0] filt_reg;
    logic signed [hbd_pkg::ACC_W-1:0]  prod_reg;
    logic signed [hbd_pkg::SAMP_W-1:0] out_reg;

    logic signed [hbd_pkg::COEF_W-1:0] coef;
    logic signed [hbd_pkg::ACC_W-1:0]  mac_prod;
    logic signed [hbd_pkg::ACC_W-1:0]  filt_shr;
    logic signed [hbd_pkg::ACC_W-1:0]  gain_shr;
    logic signed [hbd_pkg::CFG_W:0]    gain_s;

    assign coef     = hbd_pkg::hbd_coef(cmd.coef_sel);
    assign mac_prod = hbd_pkg::ACC_W'(work_reg[0]) * hbd_pkg::ACC_W'(coef);
    assign filt_shr = (acc_reg + hbd_pkg::FILT_ROUND) >>> hbd_pkg::FILT_SHIFT;
    assign gain_shr = (prod_reg + hbd_pkg::GAIN_ROUND) >>> hbd_pkg::GAIN_SHIFT;
    assign gain_s   = {1'b0, mic_gain};

    // Delay line, pair phase and discard counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                dly_reg[i] <= '0;
            end
            phase_reg   <= 1'b0;
            discard_reg <= '0;
        end else if (cmd.clear) begin
            for (int i = 0; i < TAPS; i++) begin
                dly_reg[i] <= '0;
            end
            phase_reg   <= 1'b0;
            discard_reg <= discard_count;
        end else if (cmd.discard) begin
            discard_reg <= discard_reg - 1'b1;
        end else if (cmd.shift_in) begin
            dly_reg[0] <= sample_in;
            for (int i = 1; i < TAPS; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
            phase_reg <= !phase_reg;
        end
    end

    // Folded work line and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.load_work) begin
            for (int j = 0; j < NW - 1; j++) begin
                work_reg[j] <= hbd_pkg::PAIR_W'(dly_reg[2*j])
                             + hbd_pkg::PAIR_W'(dly_reg[TAPS-1-2*j]);
            end
            work_reg[NW-1] <= hbd_pkg::PAIR_W'(dly_reg[(TAPS-1)/2]);
            acc_reg        <= '0;
        end else if (cmd.mac_step) begin
            for (int j = 0; j < NW - 1; j++) begin
                work_reg[j] <= work_reg[j+1];
            end
            work_reg[NW-1] <= '0;
            acc_reg        <= acc_reg + mac_prod;
        end
    end

    // Rounding, gain and output register
    always_ff @(posedge clk)
    begin
        if (cmd.round) begin
            filt_reg <= hbd_pkg::hbd_sat16(filt_shr);
        end
        if (cmd.gain) begin
            prod_reg <= hbd_pkg::ACC_W'(filt_reg) * hbd_pkg::ACC_W'(gain_s);
        end
        if (cmd.out_load) begin
            out_reg <= hbd_pkg::hbd_sat16(gain_shr);
        end
    end

    assign status.discard_zero = (discard_reg == '0);
    assign status.phase        = phase_reg;
    assign sample_out          = out_reg;

endmodule
`default_nettype wire

### rtl/core/halfband_decimator_with_gain_top.sv
// Top level of the half-band decimate-by-two filter with output gain.
`default_nettype none
//
// Channel   | Direction | Transaction carries
// ----------+-----------+----------------------------------------------------
// s_axis    | in        | tuser[0] = restart, tdata[31:0] = slot
// m_axis    | out       | tdata[15:0] = sample
// APB       | in/out    | 0x0 mic_gain (Q8), 0x4 discard_count
//
// Restart, discarded and first-of-pair transactions are handled in the idle
// state. A second-of-pair sample steps through fold load, eight MAC steps on
// one multiplier shared by the steps, filter rounding, gain multiply and output
// write; no new input transaction is taken until the controller is idle again.
// Reset clears the delay line, pair phase, discard counter and loads the
// register defaults (gain 256, discard 0); no clearing pass is needed.
// A stalled output holds its value; the next sample is taken while the
// result waits, and the block stalls only at the output write.
//
module halfband_decimator_with_gain_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] slot
    input  wire logic [0:0]  s_axis_tuser,   // [0] restart
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [hbd_pkg::CFG_W-1:0]         mic_gain_reg;
    logic [hbd_pkg::CFG_W-1:0]         discard_count_reg;
    logic                              cfg_write;
    hbd_pkg::hbd_cmd_t                 cmd;
    hbd_pkg::hbd_status_t              status;
    logic signed [hbd_pkg::SAMP_W-1:0] sample_out;

    // Register file: decode on bit 2 only, so every address hits a register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mic_gain_reg      <= hbd_pkg::GAIN_RESET;
            discard_count_reg <= hbd_pkg::DISCARD_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == hbd_pkg::ADDR_DISCARD_COUNT[2]) begin
                discard_count_reg <= pwdata[hbd_pkg::CFG_W-1:0];
            end else begin
                mic_gain_reg <= pwdata[hbd_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == hbd_pkg::ADDR_DISCARD_COUNT[2]) begin
            prdata = {16'd0, discard_count_reg};
        end else begin
            prdata = {16'd0, mic_gain_reg};
        end
    end

    // Sequencer: owns the handshakes and steps the datapath
    hbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_restart (s_axis_tuser[0]),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: keep the top 16 bits of the slot as the sample
    hbd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_in     (s_axis_tdata[31:16]),
        .mic_gain      (mic_gain_reg),
        .discard_count (discard_count_reg),
        .status        (status),
        .sample_out    (sample_out)
    );

    assign m_axis_tdata = sample_out;

endmodule
`default_nettype wire

### rtl/core/hbd_checker.sv
// Port-level checker for the half-band decimator, bound to the top level.
`default_nettype none
module hbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // A restart never produces a result
    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after restart");

    // Read back the gain register after a write
    a_gain_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || prdata[15:0] == $past(pwdata[15:0]))
        else $error("mic_gain readback mismatch");

    // Read back the discard register after a write
    a_discard_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2]
        |=> !paddr[2] || prdata[15:0] == $past(pwdata[15:0]))
        else $error("discard_count readback mismatch");

endmodule

bind halfband_decimator_with_gain_top hbd_checker u_hbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
`default_nettype wire

### verif/tb_halfband_decimator_with_gain_top.sv
// Self-checking testbench of the half-band decimate-by-two filter with output gain.
module tb_halfband_decimator_with_gain_top;

    // One input transaction: restart flag and raw microphone slot
    typedef struct packed {
        logic        restart;
        logic [31:0] slot;
    } mic_item_t;

    // Shapes of random traffic
    typedef enum int {
        BURST_SATURATE,   // restart, discards, then a full-scale pattern that clips the filter
        BURST_RESTART,    // lone restart
        BURST_RUN         // short run of random samples
    } burst_t;

    localparam int TAPS         = hbd_pkg::TAPS;
    localparam int LATENCY_WAIT = 32;   // wait after draining, with margin over the second-of-pair work

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] slot
    logic [0:0]  s_axis_tuser = '0;     // [0] restart

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] sample

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    halfband_decimator_with_gain_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Traffic control shared by the stimulus, driver and sink
    mic_item_t mic_items[$];
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    logic      in_accepted = 1'b0;
    logic      rx_hold = 1'b0;
    logic      stall_go = 1'b0;
    int        errors = 0;

    // Predictor state: delay line, write pointer, pair phase, discard counter, register copies, expected samples
    logic signed [15:0] history [TAPS] = '{default: '0};
    int                 wr_pos = 0;
    logic               pair_phase = 1'b0;
    logic [15:0]        discard_left = '0;
    logic [15:0]        gain_cfg = hbd_pkg::GAIN_RESET;
    logic [15:0]        discard_cfg = hbd_pkg::DISCARD_RESET;
    logic signed [15:0] expected_samples[$];

    // Half-band tap k of the symmetric Q15 filter, center at TAPS/2
    function automatic int hb_tap(input int k);
        int d;
        int c;
        d = (k > TAPS / 2) ? k - TAPS / 2 : TAPS / 2 - k;
        case (d)
            0:       c = 16384;
            1:       c = 10252;
            3:       c = -3063;
            5:       c = 1461;
            7:       c = -719;
            9:       c = 322;
            11:      c = -125;
            13:      c = 64;
            default: c = 0;
        endcase
        return c;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Advance the decimator by one accepted transaction; queue the sample it emits
    function automatic void decimate_sample(input logic restart, input logic [31:0] slot);
        longint acc;
        longint filt;
        longint scaled;
        int     idx;
        if (restart)
        begin
            for (int i = 0; i < TAPS; i++)
                history[i] = '0;
            wr_pos       = 0;
            pair_phase   = 1'b0;
            discard_left = discard_cfg;
            return;
        end
        if (discard_left != 0)
        begin
            discard_left = discard_left - 16'd1;
            return;
        end
        history[wr_pos] = slot[31:16];
        wr_pos          = (wr_pos == TAPS - 1) ? 0 : wr_pos + 1;
        pair_phase      = ~pair_phase;
        if (pair_phase)
            return;
        // wr_pos now points at the oldest entry, which meets tap 0
        acc = 0;
        for (int k = 0; k < TAPS; k++)
        begin
            idx = wr_pos + k;
            if (idx >= TAPS)
                idx -= TAPS;
            acc += longint'(hb_tap(k)) * longint'(history[idx]);
        end
        filt   = clip16((acc + 64'sd16384) >>> 15);
        scaled = clip16((filt * longint'(gain_cfg) + 64'sd128) >>> 8);
        expected_samples.push_back(scaled[15:0]);
    endfunction

    function automatic void add_item(input logic restart, input logic [31:0] slot);
        mic_item_t it;
        it.restart = restart;
        it.slot    = slot;
        mic_items.push_back(it);
    endfunction

    // Queue roughly `count` transactions of mixed shapes; `disc` is the discard count
    // in force, so saturating bursts line up after the start-up drop.
    task automatic queue_traffic(input int count, input int disc);
        int          added;
        int          pick;
        burst_t      burst;
        logic        neg;
        logic [15:0] top;
        logic [31:0] r;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                burst = BURST_SATURATE;
            else if (pick == 1)
                burst = BURST_RESTART;
            else
                burst = BURST_RUN;
            case (burst)
                BURST_SATURATE:
                begin
                    add_item(1'b1, $urandom);
                    for (int i = 0; i < disc; i++)
                        add_item(1'b0, $urandom);
                    // After 28 samples, sample j (1..27) meets tap j-1: match each sign
                    neg = 1'($urandom_range(1));
                    for (int j = 0; j < 28; j++)
                    begin
                        r = $urandom;
                        if (j == 0)
                            top = r[31:16];
                        else
                            top = ((hb_tap(j - 1) < 0) ^ neg) ? 16'h8000 : 16'h7fff;
                        add_item(1'b0, {top, r[15:0]});
                    end
                    added += 29 + disc;
                end
                BURST_RESTART:
                begin
                    add_item(1'b1, $urandom);
                    added++;
                end
                default:
                begin
                    for (int i = $urandom_range(1, 12); i > 0; i--)
                    begin
                        r = $urandom;
                        // pin the sample to a rail now and then
                        if ($urandom_range(7) == 0)
                            r[31:16] = $urandom_range(1) ? 16'h7fff : 16'h8000;
                        add_item(1'b0, r);
                        added++;
                    end
                end
            endcase
        end
    endtask

    // Register write: setup cycle, then access cycle; inputs move on falling edges
    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every queued transaction is accepted and every sample is back,
    // then let the block finish any work that emits nothing
    task automatic drain;
        while (mic_items.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // Driver: offer the next item once the current one is taken, or idle at random
    always @(negedge clk)
    begin : feed
        mic_item_t it;
        if (rst_n && (!s_axis_tvalid || in_accepted))
        begin
            if (mic_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                it = mic_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.restart;
                s_axis_tdata  <= it.slot;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink: stall at random, or hold off entirely during the back-pressure window
    always @(negedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Back-pressure window: count the held cycles here, independent of the stimulus
    initial
    begin
        wait (stall_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: track register writes, predict on input transactions, check outputs
    always @(posedge clk)
    begin : observe
        logic signed [15:0] want;
        if (rst_n)
        begin
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    hbd_pkg::ADDR_MIC_GAIN:      gain_cfg = pwdata[15:0];
                    hbd_pkg::ADDR_DISCARD_COUNT: discard_cfg = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decimate_sample(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected sample %0d", $signed(m_axis_tdata));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("sample mismatch: expected %0d, got %0d",
                                     want, $signed(m_axis_tdata));
                    end
                end
            end
        end
    end

    // Stimulus: phases at several register settings, each drained before the next write
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unity gain, three start-up discards; sender idles a third, sink most cycles
        write_reg(hbd_pkg::ADDR_MIC_GAIN, 16'd256);
        write_reg(hbd_pkg::ADDR_DISCARD_COUNT, 16'd3);
        @(posedge clk);
        tx_idle_pct = 33;
        rx_idle_pct = 77;
        add_item(1'b1, 32'h0000_0000);
        add_item(1'b0, 32'h7fff_ffff);       // dropped by the discard count
        add_item(1'b0, 32'h8000_0000);
        add_item(1'b0, 32'hffff_ffff);
        add_item(1'b0, 32'h7fff_0000);       // pairs of rails and near-zero values
        add_item(1'b0, 32'h8000_0000);
        add_item(1'b0, 32'hffff_ffff);
        add_item(1'b0, 32'h0000_0000);
        add_item(1'b0, 32'h0000_ffff);
        add_item(1'b0, 32'h0001_0000);
        add_item(1'b0, 32'h7fff_ffff);
        add_item(1'b0, 32'h7fff_1234);
        add_item(1'b0, 32'h8000_8000);       // first of a pair, then restart mid-pair
        add_item(1'b1, 32'hffff_ffff);
        add_item(1'b0, $urandom);
        add_item(1'b0, $urandom);
        add_item(1'b0, $urandom);
        add_item(1'b0, 32'h1234_5678);
        add_item(1'b0, 32'h8000_0000);
        add_item(1'b0, 32'h7fff_0000);
        add_item(1'b0, 32'hc000_0000);
        queue_traffic(150, 3);
        drain();

        // Full-scale gain drives the output into clipping; idle ratios swapped
        write_reg(hbd_pkg::ADDR_MIC_GAIN, 16'hffff);
        write_reg(hbd_pkg::ADDR_DISCARD_COUNT, 16'd0);
        @(posedge clk);
        tx_idle_pct = 77;
        rx_idle_pct = 33;
        queue_traffic(130, 0);
        drain();

        // Zero gain on a running stream, then load the largest discard count and
        // feed samples that are all dropped; no idling from here on
        write_reg(hbd_pkg::ADDR_MIC_GAIN, 16'd0);
        write_reg(hbd_pkg::ADDR_DISCARD_COUNT, 16'hffff);
        @(posedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 20; i++)
            add_item(1'b0, $urandom);
        add_item(1'b1, $urandom);
        for (int i = 0; i < 30; i++)
            add_item(1'b0, $urandom);
        drain();

        // Random gain, single discard; the sink holds off so the block backs up
        write_reg(hbd_pkg::ADDR_MIC_GAIN, 16'($urandom_range(1, 16'hfffe)));
        write_reg(hbd_pkg::ADDR_DISCARD_COUNT, 16'd1);
        @(posedge clk);
        add_item(1'b1, $urandom);
        stall_go = 1'b1;
        queue_traffic(120, 1);
        drain();

        // Half gain, no discards, full rate both sides
        write_reg(hbd_pkg::ADDR_MIC_GAIN, 16'd128);
        write_reg(hbd_pkg::ADDR_DISCARD_COUNT, 16'd0);
        @(posedge clk);
        queue_traffic(100, 0);
        drain();

        if (errors == 0)
            $display("[halfband_decimator_with_gain_top] OK");
        else
            $display("[halfband_decimator_with_gain_top] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(12 * 300000);
        $display("[halfband_decimator_with_gain_top] ERROR");
        $finish;
    end

endmodule
